// File: rtl/amt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amt_pkg
// Shared types and constants for the adaptive mean threshold block.
// ----------------------------------------------------------------------------
package amt_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_WINDOW     = 11;

   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CFG_DIM_W  = 11;
   localparam int GRAY_W     = 8;

   localparam logic [CFG_DIM_W-1:0] RST_FRAME_WIDTH  = 11'd320;
   localparam logic [CFG_DIM_W-1:0] RST_FRAME_HEIGHT = 11'd240;
   localparam logic [GRAY_W-1:0]    RST_MEAN_OFFSET  = 8'd7;

   localparam logic [GRAY_W-1:0] PIX_WHITE = 8'd255;
   localparam logic [GRAY_W-1:0] PIX_BLACK = 8'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_MEAN_OFFSET  = 2'd2
   } csr_index_type;

   typedef enum logic {
      CMD_PIXEL = 1'b0,
      CMD_FLUSH = 1'b1
   } cmd_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_BACK = 6'b000010,
      ST_SCAN = 6'b000100,
      ST_TAIL = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

endpackage

// File: rtl/adaptive_mean_threshold_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_mean_threshold_top
// Streaming adaptive mean binarizer with a ring line store and a shared
// accumulate / divide datapath.
// ----------------------------------------------------------------------------
// An item that gives no result leaves the block idle. For an item that gives
// a result, the block walks the read address back over the rows above the
// pixel inside the window (at most WINDOW/2), then reads the window, clipped
// at the frame edges, one pixel per cycle, since the line store has one read
// port. It forms the mean with a restoring divider that yields one quotient
// bit per cycle over the SUM_W bits of the window sum (15 for an 11x11
// window). The input stalls until the result is loaded. Results leave in
// raster order, WINDOW/2 rows plus WINDOW/2 pixels behind the input; after the
// last pixel the host sends flush items until frame_last is seen. A write to
// configuration index 0 to 2 while idle starts a new frame; writes while busy
// are dropped. The input stalls in the cycle of the write.
module adaptive_mean_threshold_top
   import amt_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int WINDOW     = DEF_WINDOW
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic [GRAY_W-1:0]     req_gray_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [GRAY_W-1:0]     rsp_binary_value,
   output logic                  rsp_frame_last,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int HALF    = WINDOW / 2;
   localparam int DEPTH   = WINDOW * MAX_WIDTH;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int W_W     = $clog2(MAX_WIDTH + 1);
   localparam int H_W     = $clog2(MAX_HEIGHT + 1);
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int POS_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int HALF_W  = $clog2(HALF + 1);
   localparam int SPAN_W  = $clog2(WINDOW + 1);
   localparam int SUM_W   = $clog2(WINDOW * WINDOW * 255 + 1);
   localparam int CNT_W   = $clog2(WINDOW * WINDOW + 1);
   localparam int BIT_W   = $clog2(SUM_W + 1);
   localparam int DIM_X_W = (CFG_DIM_W > W_W ? CFG_DIM_W : W_W) + 1;
   localparam int DIM_Y_W = (CFG_DIM_W > H_W ? CFG_DIM_W : H_W) + 1;

   // Ring address arithmetic modulo the store depth; k is below DEPTH.
   function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] k);
      logic [ADDR_W:0] s;
      s = {1'b0, a} + {1'b0, k};
      if (s >= (ADDR_W+1)'(DEPTH)) s = s - (ADDR_W+1)'(DEPTH);
      return s[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] ring_sub(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] k);
      logic [ADDR_W:0] s;
      if (a >= k) s = {1'b0, a} - {1'b0, k};
      else s = {1'b0, a} + (ADDR_W+1)'(DEPTH) - {1'b0, k};
      return s[ADDR_W-1:0];
   endfunction

   // Configuration.
   logic [CFG_DIM_W-1:0] width_ff, width_in;
   logic [CFG_DIM_W-1:0] height_ff, height_in;
   logic [GRAY_W-1:0]    offset_ff, offset_in;

   // Frame bookkeeping.
   logic [POS_W-1:0]  taken_ff, taken_in;
   logic [POS_W-1:0]  given_ff, given_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [ADDR_W-1:0] g_addr_ff, g_addr_in;
   logic [ROW_W-1:0]  g_row_ff, g_row_in;
   logic [COL_W-1:0]  g_col_ff, g_col_in;

   // Sequencer and shared datapath.
   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [HALF_W-1:0] back_ff, back_in;
   logic [SPAN_W-1:0] rows_left_ff, rows_left_in;
   logic [SPAN_W-1:0] col_ff, col_in;
   logic              acc_vld_ff, acc_vld_in;
   logic [SUM_W-1:0]  div_ff, div_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;

   // Result register.
   logic              out_vld_ff, out_vld_in;
   logic [GRAY_W-1:0] out_bin_ff, out_bin_in;
   logic              out_last_ff, out_last_in;

   // Line store.
   logic [GRAY_W-1:0] mem [DEPTH];
   logic [GRAY_W-1:0] mem_q;
   logic              mem_we;

   logic [DIM_X_W-1:0] w_sat;
   logic [DIM_Y_W-1:0] h_sat;
   logic [W_W-1:0]     w_use;
   logic [H_W-1:0]     h_use;
   logic [POS_W-1:0]   total;
   logic [POS_W:0]     lag;
   logic [HALF_W-1:0]  rows_up, rows_dn, cols_l, cols_r;
   logic [SPAN_W-1:0]  span, rows_span;
   logic               accept, pix_take, produce, load_out, frame_end;
   logic [POS_W-1:0]   taken_nxt;
   logic [CNT_W:0]     rem_sh;
   logic [SUM_W-1:0]   thr;
   logic [ROW_W:0]     rows_below;
   logic [COL_W:0]     cols_right;

   always_comb begin
      w_sat = DIM_X_W'(width_ff);
      h_sat = DIM_Y_W'(height_ff);
      if (w_sat == '0) w_use = W_W'(1);
      else if (w_sat > DIM_X_W'(MAX_WIDTH)) w_use = W_W'(MAX_WIDTH);
      else w_use = w_sat[W_W-1:0];
      if (h_sat == '0) h_use = H_W'(1);
      else if (h_sat > DIM_Y_W'(MAX_HEIGHT)) h_use = H_W'(MAX_HEIGHT);
      else h_use = h_sat[H_W-1:0];
      total = POS_W'(w_use) * POS_W'(h_use);
      lag   = (POS_W+1)'(HALF * w_use + HALF);
   end

   // Extent of the clipped window around the current result pixel.
   always_comb begin
      rows_below = (ROW_W+1)'(h_use) - (ROW_W+1)'(g_row_ff) - (ROW_W+1)'(1);
      cols_right = (COL_W+1)'(w_use) - (COL_W+1)'(g_col_ff) - (COL_W+1)'(1);
      rows_up = (g_row_ff > ROW_W'(HALF)) ? HALF_W'(HALF) : HALF_W'(g_row_ff);
      rows_dn = (rows_below > (ROW_W+1)'(HALF)) ? HALF_W'(HALF) : HALF_W'(rows_below);
      cols_l  = (g_col_ff > COL_W'(HALF)) ? HALF_W'(HALF) : HALF_W'(g_col_ff);
      cols_r  = (cols_right > (COL_W+1)'(HALF)) ? HALF_W'(HALF) : HALF_W'(cols_right);
      span      = SPAN_W'(cols_l) + SPAN_W'(cols_r) + SPAN_W'(1);
      rows_span = SPAN_W'(rows_up) + SPAN_W'(rows_dn);
   end

   assign req_stall = (state_ff != ST_IDLE) || csr_wr_en;
   assign accept    = req_valid && !req_stall;
   assign pix_take  = accept && (req_cmd == CMD_PIXEL) && (taken_ff < total);
   assign taken_nxt = taken_ff + POS_W'(pix_take);
   assign produce   = (given_ff < total) && (given_ff < taken_nxt) &&
                      ((taken_nxt == total) ||
                       ((POS_W+1)'(taken_nxt) >= (POS_W+1)'(given_ff) + lag + (POS_W+1)'(1)));
   assign mem_we    = pix_take;
   assign load_out  = (state_ff == ST_DONE) && !out_vld_ff;
   assign frame_end = (given_ff + POS_W'(1)) == total;
   assign rem_sh    = {rem_ff, div_ff[SUM_W-1]};
   assign thr = (div_ff > SUM_W'(offset_ff)) ? div_ff - SUM_W'(offset_ff) : '0;

   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      offset_in    = offset_ff;
      taken_in     = taken_ff;
      given_in     = given_ff;
      wr_addr_in   = wr_addr_ff;
      g_addr_in    = g_addr_ff;
      g_row_in     = g_row_ff;
      g_col_in     = g_col_ff;
      state_in     = state_ff;
      addr_in      = addr_ff;
      back_in      = back_ff;
      rows_left_in = rows_left_ff;
      col_in       = col_ff;
      acc_vld_in   = 1'b0;
      div_in       = div_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      out_vld_in   = out_vld_ff && rsp_stall;
      out_bin_in   = out_bin_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (csr_wr_en && csr_index <= CSR_MEAN_OFFSET) begin
               case (csr_index)
                  CSR_FRAME_WIDTH:  width_in  = csr_wdata;
                  CSR_FRAME_HEIGHT: height_in = csr_wdata;
                  default:          offset_in = csr_wdata[GRAY_W-1:0];
               endcase
               taken_in   = '0;
               given_in   = '0;
               wr_addr_in = '0;
               g_addr_in  = '0;
               g_row_in   = '0;
               g_col_in   = '0;
            end else if (accept) begin
               if (given_ff >= total) begin
                  taken_in   = '0;
                  given_in   = '0;
                  wr_addr_in = '0;
                  g_addr_in  = '0;
                  g_row_in   = '0;
                  g_col_in   = '0;
               end else begin
                  taken_in = taken_nxt;
                  if (pix_take) wr_addr_in = ring_add(wr_addr_ff, ADDR_W'(1));
                  if (produce) begin
                     addr_in  = g_addr_ff;
                     back_in  = rows_up;
                     state_in = ST_BACK;
                  end
               end
            end
         end
         ST_BACK: begin
            if (back_ff != '0) begin
               addr_in = ring_sub(addr_ff, ADDR_W'(w_use));
               back_in = back_ff - HALF_W'(1);
            end else begin
               addr_in      = ring_sub(addr_ff, ADDR_W'(cols_l));
               rows_left_in = rows_span;
               col_in       = '0;
               div_in       = '0;
               count_in     = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // The read of addr_ff lands in mem_q in the next cycle.
            acc_vld_in = 1'b1;
            if (acc_vld_ff) begin
               div_in   = div_ff + SUM_W'(mem_q);
               count_in = count_ff + CNT_W'(1);
            end
            if (col_ff == span - SPAN_W'(1)) begin
               col_in = '0;
               if (rows_left_ff == '0) begin
                  addr_in  = g_addr_ff;
                  state_in = ST_TAIL;
               end else begin
                  addr_in      = ring_add(addr_ff,
                                          ADDR_W'(w_use) - ADDR_W'(span) + ADDR_W'(1));
                  rows_left_in = rows_left_ff - SPAN_W'(1);
               end
            end else begin
               addr_in = ring_add(addr_ff, ADDR_W'(1));
               col_in  = col_ff + SPAN_W'(1);
            end
         end
         ST_TAIL: begin
            div_in   = div_ff + SUM_W'(mem_q);
            count_in = count_ff + CNT_W'(1);
            rem_in   = '0;
            bit_in   = BIT_W'(SUM_W);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // Restoring division, one quotient bit per cycle.
            if (bit_ff != '0) begin
               if (rem_sh >= {1'b0, count_ff}) begin
                  rem_in = CNT_W'(rem_sh - {1'b0, count_ff});
                  div_in = {div_ff[SUM_W-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh[CNT_W-1:0];
                  div_in = {div_ff[SUM_W-2:0], 1'b0};
               end
               bit_in = bit_ff - BIT_W'(1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // mem_q holds the center pixel, read during the tail cycle.
            if (load_out) begin
               out_vld_in  = 1'b1;
               out_bin_in  = (SUM_W'(mem_q) < thr) ? PIX_BLACK : PIX_WHITE;
               out_last_in = frame_end;
               state_in    = ST_IDLE;
               if (frame_end) begin
                  taken_in   = '0;
                  given_in   = '0;
                  wr_addr_in = '0;
                  g_addr_in  = '0;
                  g_row_in   = '0;
                  g_col_in   = '0;
               end else begin
                  given_in  = given_ff + POS_W'(1);
                  g_addr_in = ring_add(g_addr_ff, ADDR_W'(1));
                  if ((COL_W+1)'(g_col_ff) == (COL_W+1)'(w_use) - (COL_W+1)'(1)) begin
                     g_col_in = '0;
                     g_row_in = g_row_ff + ROW_W'(1);
                  end else begin
                     g_col_in = g_col_ff + COL_W'(1);
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr_ff] <= req_gray_value;
      mem_q <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= RST_FRAME_WIDTH;
         height_ff  <= RST_FRAME_HEIGHT;
         offset_ff  <= RST_MEAN_OFFSET;
         taken_ff   <= '0;
         given_ff   <= '0;
         wr_addr_ff <= '0;
         g_addr_ff  <= '0;
         g_row_ff   <= '0;
         g_col_ff   <= '0;
         state_ff   <= ST_IDLE;
         acc_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         offset_ff  <= offset_in;
         taken_ff   <= taken_in;
         given_ff   <= given_in;
         wr_addr_ff <= wr_addr_in;
         g_addr_ff  <= g_addr_in;
         g_row_ff   <= g_row_in;
         g_col_ff   <= g_col_in;
         state_ff   <= state_in;
         acc_vld_ff <= acc_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      back_ff      <= back_in;
      rows_left_ff <= rows_left_in;
      col_ff       <= col_in;
      div_ff       <= div_in;
      count_ff     <= count_in;
      rem_ff       <= rem_in;
      bit_ff       <= bit_in;
      out_bin_ff   <= out_bin_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_binary_value = out_bin_ff;
   assign rsp_frame_last   = out_last_ff;

`ifndef SYNTHESIS
   // A result is never produced for a pixel that has not arrived.
   a_given_le_taken: assert property (@(posedge clock) disable iff (reset)
      given_ff <= taken_ff)
      else $error("result index ran ahead of input index");

   // The divider never starts with an empty window.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (count_ff != '0))
      else $error("division by an empty window count");

   // The last result of a frame returns both counters to the frame start.
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (load_out && frame_end) |=> (taken_ff == '0 && given_ff == '0))
      else $error("counters not cleared at end of frame");
`endif

endmodule

// File: tb/adaptive_mean_threshold_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_mean_threshold_top_tb
// Streams gray frames of many sizes and offsets through the binarizer. A
// local model of the line store and the frame counters computes every
// expected pixel, and each result transfer is checked in order against it.
// ----------------------------------------------------------------------------
module adaptive_mean_threshold_top_tb;
   import amt_pkg::*;

   localparam int MAX_W       = DEF_MAX_WIDTH;
   localparam int MAX_H       = DEF_MAX_HEIGHT;
   localparam int HALF        = DEF_WINDOW / 2;
   localparam int STORE_DEPTH = DEF_WINDOW * DEF_MAX_WIDTH;
   localparam int SETTLE      = 400;
   localparam int CYCLE_LIMIT = 6000000;
   localparam int ITEM_GOAL   = 1800;

   typedef struct {
      logic [GRAY_W-1:0] binary_value;
      logic              frame_last;
   } bin_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   cmd_type               req_cmd;
   logic [GRAY_W-1:0]     req_gray_value;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [GRAY_W-1:0]     rsp_binary_value;
   logic                  rsp_frame_last;
   logic                  csr_wr_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Local copy of the block's state and registers.
   logic [GRAY_W-1:0]    line_mem [STORE_DEPTH];
   int unsigned          px_taken;
   int unsigned          px_given;
   logic [CFG_DIM_W-1:0] cfg_width;
   logic [CFG_DIM_W-1:0] cfg_height;
   logic [GRAY_W-1:0]    cfg_offset;

   bin_result_type pending_pixels[$];
   int             error_count;
   int             item_count;
   longint         cycle_count;
   bit             calm;

   adaptive_mean_threshold_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_gray_value   (req_gray_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_binary_value (rsp_binary_value),
      .rsp_frame_last   (rsp_frame_last),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int unsigned eff_size(logic [CFG_DIM_W-1:0] v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Window mean over the clipped neighborhood, then the offset threshold.
   function automatic logic [GRAY_W-1:0] binarize(int unsigned pos, int unsigned w,
                                                  int unsigned h);
      int unsigned r, c, r0, r1, c0, c1, sum, count, mean, thr;
      r = pos / w;
      c = pos % w;
      r0 = (r > HALF) ? r - HALF : 0;
      r1 = (r + HALF < h) ? r + HALF : h - 1;
      c0 = (c > HALF) ? c - HALF : 0;
      c1 = (c + HALF < w) ? c + HALF : w - 1;
      sum = 0;
      count = 0;
      for (int unsigned y = r0; y <= r1; y++) begin
         for (int unsigned x = c0; x <= c1; x++) begin
            sum += line_mem[(y * w + x) % STORE_DEPTH];
            count++;
         end
      end
      mean = sum / count;
      thr = (mean > cfg_offset) ? mean - cfg_offset : 0;
      return (line_mem[pos % STORE_DEPTH] < thr) ? PIX_BLACK : PIX_WHITE;
   endfunction

   task automatic advance_frame(cmd_type cmd, logic [GRAY_W-1:0] gray);
      int unsigned w, h, total, lag;
      bin_result_type res;
      w = eff_size(cfg_width, MAX_W);
      h = eff_size(cfg_height, MAX_H);
      total = w * h;
      lag = HALF * w + HALF;
      if (cmd == CMD_PIXEL && px_taken < total) begin
         line_mem[px_taken % STORE_DEPTH] = gray;
         px_taken++;
      end
      if (px_given >= total) begin
         px_taken = 0;
         px_given = 0;
      end else if ((px_taken == total || px_taken >= px_given + lag + 1)
                   && px_given < px_taken) begin
         res.binary_value = binarize(px_given, w, h);
         px_given++;
         res.frame_last = (px_given == total);
         if (res.frame_last) begin
            px_taken = 0;
            px_given = 0;
         end
         pending_pixels.push_back(res);
      end
   endtask

   task automatic send_item(cmd_type cmd, logic [GRAY_W-1:0] gray);
      int gap;
      gap = random_gap();
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_gray_value <= gray;
      do @(posedge clock); while (req_stall);
      advance_frame(cmd, gray);
      item_count++;
   endtask

   task automatic wait_idle();
      @(negedge clock) req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock) csr_wr_en <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH:  cfg_width = value;
         CSR_FRAME_HEIGHT: cfg_height = value;
         CSR_MEAN_OFFSET:  cfg_offset = value[GRAY_W-1:0];
         default: ;
      endcase
      px_taken = 0;
      px_given = 0;
   endtask

   task automatic set_frame(int w, int h, int offset);
      wait_idle();
      write_csr(CSR_FRAME_WIDTH, CSR_DATA_W'(w));
      write_csr(CSR_FRAME_HEIGHT, CSR_DATA_W'(h));
      write_csr(CSR_MEAN_OFFSET, CSR_DATA_W'(offset));
   endtask

   // Sends flushes (or stray pixels, which the block drops) until the frame ends.
   task automatic drain_frame(int stray_pct);
      while (px_taken != 0 || px_given != 0) begin
         if ($urandom_range(0, 99) < stray_pct)
            send_item(CMD_PIXEL, GRAY_W'($urandom_range(0, 255)));
         else
            send_item(CMD_FLUSH, GRAY_W'($urandom_range(0, 255)));
      end
   endtask

   task automatic stream_frame(int mode, int noise_pct);
      int unsigned total, base;
      logic [GRAY_W-1:0] g;
      total = eff_size(cfg_width, MAX_W) * eff_size(cfg_height, MAX_H);
      base = $urandom_range(0, 255);
      for (int unsigned i = 0; i < total; i++) begin
         if ($urandom_range(0, 99) < noise_pct)
            send_item(CMD_FLUSH, GRAY_W'($urandom_range(0, 255)));
         case (mode)
            0: g = GRAY_W'($urandom_range(0, 255));
            1: g = GRAY_W'(base + i * 3 + $urandom_range(0, 15));
            default: g = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         endcase
         send_item(CMD_PIXEL, g);
      end
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      bin_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("unexpected result transfer", rsp_binary_value, -1);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_binary_value !== want.binary_value)
               report_mismatch("binary_value", rsp_binary_value, want.binary_value);
            if (rsp_frame_last !== want.frame_last)
               report_mismatch("frame_last", rsp_frame_last, want.frame_last);
         end
      end
   end

   // Result-side back-pressure: mostly short stalls, a few long ones.
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (calm || $urandom_range(0, 99) < 65) begin
            rsp_stall <= 1'b0;
         end else begin
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            repeat (hold - 1) @(negedge clock);
         end
      end
   end

   // Pixels pushed at the reset geometry never produce a result; a write aborts the frame.
   task automatic test_reset_geometry_abort();
      for (int i = 0; i < 12; i++) send_item(CMD_PIXEL, GRAY_W'($urandom_range(0, 255)));
      send_item(CMD_FLUSH, 8'h00);
      set_frame(3, 2, 0);
      stream_frame(0, 0);
      drain_frame(0);
   endtask

   task automatic test_single_pixel();
      set_frame(1, 1, 0);
      send_item(CMD_PIXEL, 8'h00);
      send_item(CMD_PIXEL, 8'hFF);
      set_frame(0, 0, 255);
      send_item(CMD_PIXEL, 8'h80);
   endtask

   // Early flush does nothing; pixels after the frame act as flushes.
   task automatic test_flush_and_stray();
      set_frame(3, 3, 255);
      send_item(CMD_FLUSH, 8'h55);
      stream_frame(0, 0);
      send_item(CMD_PIXEL, 8'hAA);
      drain_frame(100);
      set_frame(4, 2, 0);
      stream_frame(2, 0);
      drain_frame(50);
   endtask

   // A long single row, a tall single column, and a zero width read as one.
   task automatic test_size_extremes();
      set_frame(200, 1, 7);
      stream_frame(1, 0);
      drain_frame(10);
      set_frame(1, 150, 30);
      stream_frame(0, 0);
      drain_frame(10);
      set_frame(0, 3, 0);
      stream_frame(2, 0);
      drain_frame(0);
   endtask

   task automatic test_random_frames();
      int w, h, off, aborted;
      while (item_count < ITEM_GOAL - 600) begin
         calm = ($urandom_range(0, 4) == 0);
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 16);
         h = $urandom_range(0, 9);
         case ($urandom_range(0, 5))
            0: off = 0;
            1: off = 255;
            default: off = $urandom_range(0, 40);
         endcase
         set_frame(w, h, off);
         if ($urandom_range(0, 19) == 0) begin
            aborted = $urandom_range(1, 30);
            for (int i = 0; i < aborted; i++)
               send_item(CMD_PIXEL, GRAY_W'($urandom_range(0, 255)));
            continue;
         end
         stream_frame($urandom_range(0, 2), 5);
         drain_frame(15);
      end
      calm = 1'b0;
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_PIXEL;
      req_gray_value = '0;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_FRAME_WIDTH;
      csr_wdata      = '0;
      cycle_count    = 0;
      error_count    = 0;
      item_count     = 0;
      calm           = 1'b0;
      px_taken       = 0;
      px_given       = 0;
      cfg_width      = RST_FRAME_WIDTH;
      cfg_height     = RST_FRAME_HEIGHT;
      cfg_offset     = RST_MEAN_OFFSET;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_reset_geometry_abort();
      test_single_pixel();
      test_flush_and_stray();
      test_random_frames();
      test_size_extremes();

      wait_idle();
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// File: filelist.f
rtl/amt_pkg.sv
rtl/adaptive_mean_threshold_top.sv
tb/adaptive_mean_threshold_top_tb.sv
